// ===== rtl/gsu_pkg.sv =====
// Package for the GSM septet unpacker: constants, shared types and alphabet tables.
`timescale 1ns / 1ps

package gsu_pkg;

	localparam int GSU_OCTET_BITS = 8;
	localparam int GSU_QUEUE_DEPTH = 2;

	localparam logic [6:0] GSU_ESC_SEPTET = 7'd27;
	localparam logic [15:0] GSU_UNMAPPED = 16'h003F;

	// one decoded slot: septet plus how to look it up
	typedef struct packed {
		logic [6:0] septet;
		logic       ext;
		logic       is_char;
		logic       msg_end;
	} gsu_slot_t;

	// one queue entry: the results of one octet, first slot always used
	typedef struct packed {
		logic      two;
		gsu_slot_t second;
		gsu_slot_t first;
	} gsu_entry_t;

	localparam logic [15:0] GSU_BASIC_SET [128] = '{
		16'h0040, 16'h00A3, 16'h0024, 16'h00A5, 16'h00E8, 16'h00E9, 16'h00F9, 16'h00EC,
		16'h00F2, 16'h00C7, 16'h000A, 16'h00D8, 16'h00F8, 16'h000D, 16'h00C5, 16'h00E5,
		16'h0394, 16'h005F, 16'h03A6, 16'h0393, 16'h039B, 16'h03A9, 16'h03A0, 16'h03A8,
		16'h03A3, 16'h0398, 16'h039E, 16'h003F, 16'h00C6, 16'h00E6, 16'h00DF, 16'h00C9,
		16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h00A4, 16'h0025, 16'h0026, 16'h0027,
		16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
		16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
		16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
		16'h00A1, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
		16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
		16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
		16'h0058, 16'h0059, 16'h005A, 16'h00C4, 16'h00D6, 16'h00D1, 16'h00DC, 16'h00A7,
		16'h00BF, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
		16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
		16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
		16'h0078, 16'h0079, 16'h007A, 16'h00E4, 16'h00F6, 16'h00F1, 16'h00FC, 16'h00E0
	};

	function automatic logic [15:0] gsu_ext_lookup(input logic [6:0] s);
		logic [15:0] cp;
		case (s)
			7'd20:   cp = 16'h005E;
			7'd40:   cp = 16'h007B;
			7'd41:   cp = 16'h007D;
			7'd47:   cp = 16'h005C;
			7'd60:   cp = 16'h005B;
			7'd61:   cp = 16'h007E;
			7'd62:   cp = 16'h005D;
			7'd64:   cp = 16'h007C;
			7'd101:  cp = 16'h20AC;
			default: cp = GSU_UNMAPPED;
		endcase
		return cp;
	endfunction

endpackage

// ===== rtl/gsu_in_if.sv =====
// Octet request channel: valid/ready handshake with the payload octet and its flags.
`timescale 1ns / 1ps

interface gsu_in_if import gsu_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [GSU_OCTET_BITS-1:0] octet;
	logic                      first_octet;
	logic                      final_octet;
	logic [7:0]                text_length;

	modport source (output valid, octet, first_octet, final_octet, text_length, input ready);
	modport sink   (input valid, octet, first_octet, final_octet, text_length, output ready);
endinterface

// ===== rtl/gsu_out_if.sv =====
// Character request channel: valid/ready handshake with one decoded code point.
`timescale 1ns / 1ps

interface gsu_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_point;
	logic        char_valid;
	logic        message_end;

	modport source (output valid, code_point, char_valid, message_end, input ready);
	modport sink   (input valid, code_point, char_valid, message_end, output ready);
endinterface

// ===== rtl/gsm_septet_unpack_decode_core.sv =====
// Top level of the GSM 7-bit septet unpacker and default-alphabet decoder.
// An accepted request is written into the queue and then loaded into the output register.
// Throughput: one octet per cycle while chars.ready holds and each gives at most one
//   character; an octet that gives two characters occupies the single output register for both.
// Reset (arst_n low, asynchronous): unpacking state, queue and output valid clear at once.
`timescale 1ns / 1ps

module gsm_septet_unpack_decode_core import gsu_pkg::*; #(
	parameter int QUEUE_DEPTH = GSU_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	gsu_in_if.sink    octets,
	gsu_out_if.source chars
);

	// Front to queue: one entry per octet that yields any result (up to two characters,
	// or a bare end marker when the message closes on an escape or an empty count).
	logic       push_valid;
	logic       push_ready;
	gsu_entry_t push_entry;

	// Queue to back: the back holds the head until every slot that it uses has gone out.
	logic       pop_valid;
	logic       pop_ready;
	gsu_entry_t pop_entry;

	// Front: append each octet above the leftover bits, take one or two septets, count
	// them against the message length, and hold escape state across octets.
	gsu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.octets     (octets),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready)
	);

	// Queue: decouple the octet side from the character side so either can stall.
	gsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry),
		.pop_ready  (pop_ready)
	);

	// Back: look each septet up in the default or extension table and register it.
	gsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_entry (pop_entry),
		.pop_ready (pop_ready),
		.chars     (chars)
	);

endmodule

// ===== rtl/gsu_queue.sv =====
// Short FIFO of decoded entries between the unpacking front and the lookup back.
`timescale 1ns / 1ps

module gsu_queue import gsu_pkg::*; #(
	parameter int DEPTH = GSU_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	input  gsu_entry_t push_entry,
	output logic       push_ready,
	output logic       pop_valid,
	output gsu_entry_t pop_entry,
	input  logic       pop_ready
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	gsu_entry_t       mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/gsu_front.sv =====
// Unpacking front: takes octets, splits septets, tracks count and escape, queues entries.
`timescale 1ns / 1ps

module gsu_front import gsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	gsu_in_if.sink     octets,
	output logic       push_valid,
	output gsu_entry_t push_entry,
	input  logic       push_ready
);

	logic [6:0]  lb_q;
	logic [2:0]  lc_q;
	logic [7:0]  sd_q;
	logic [7:0]  tc_q;
	logic        esc_q;
	logic        done_q;

	logic        accept;
	logic [6:0]  lb;
	logic [2:0]  lc;
	logic [7:0]  sd;
	logic [7:0]  tc;
	logic        esc;
	logic        done;
	logic [13:0] acc;
	logic [6:0]  s_a;
	logic [6:0]  s_b;
	logic        take_a;
	logic        char_a;
	logic [7:0]  sd1;
	logic        esc1;
	logic        use_b;
	logic        take_b;
	logic        char_b;
	logic [7:0]  sd2;
	logic        esc2;
	logic        ending;
	gsu_slot_t   slot_a;
	gsu_slot_t   slot_b;
	gsu_slot_t   marker;

	assign octets.ready = push_ready;
	assign accept       = octets.valid && octets.ready;

	always_comb begin
		// a message start clears the unpacking state before this octet is used
		lb   = octets.first_octet ? 7'd0 : lb_q;
		lc   = octets.first_octet ? 3'd0 : lc_q;
		sd   = octets.first_octet ? 8'd0 : sd_q;
		tc   = octets.first_octet ? octets.text_length : tc_q;
		esc  = octets.first_octet ? 1'b0 : esc_q;
		done = octets.first_octet ? 1'b0 : done_q;

		acc = {7'd0, lb} | ({6'd0, octets.octet} << lc);
		s_a = acc[6:0];
		s_b = acc[13:7];

		take_a = (sd < tc);
		char_a = take_a && (s_a != GSU_ESC_SEPTET);
		sd1    = take_a ? sd + 8'd1 : sd;
		esc1   = take_a ? (s_a == GSU_ESC_SEPTET) : esc;

		// second septet: a full one when six bits were left, else the flush
		use_b  = (lc == 3'd6) || octets.final_octet;
		take_b = use_b && (sd1 < tc);
		char_b = take_b && (s_b != GSU_ESC_SEPTET);
		sd2    = take_b ? sd1 + 8'd1 : sd1;
		esc2   = take_b ? (s_b == GSU_ESC_SEPTET) : esc1;

		ending = octets.final_octet || (sd2 >= tc);

		slot_a = '{septet: s_a, ext: esc, is_char: 1'b1, msg_end: ending && !char_b};
		slot_b = '{septet: s_b, ext: esc1, is_char: 1'b1, msg_end: ending};
		marker = '{septet: 7'd0, ext: 1'b0, is_char: 1'b0, msg_end: 1'b1};

		push_entry.two    = char_a && char_b;
		push_entry.second = slot_b;
		if (char_a) begin
			push_entry.first = slot_a;
		end else if (char_b) begin
			push_entry.first = slot_b;
		end else begin
			push_entry.first = marker;
		end

		push_valid = accept && !done && (char_a || char_b || ending);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lb_q   <= '0;
			lc_q   <= '0;
			sd_q   <= '0;
			tc_q   <= '0;
			esc_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (accept && !done) begin
			lb_q   <= use_b ? 7'd0 : s_b;
			lc_q   <= use_b ? 3'd0 : lc + 3'd1;
			sd_q   <= sd2;
			tc_q   <= tc;
			esc_q  <= esc2;
			done_q <= ending;
		end
	end

endmodule

// ===== rtl/gsu_back.sv =====
// Lookup back: drains queue entries slot by slot into the registered character output.
`timescale 1ns / 1ps

module gsu_back import gsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	input  gsu_entry_t pop_entry,
	output logic       pop_ready,
	gsu_out_if.source  chars
);

	logic        valid_q;
	logic        idx_q;
	logic [15:0] code_q;
	logic        char_q;
	logic        end_q;

	logic        load;
	logic        last;
	gsu_slot_t   slot;
	logic [15:0] cp;

	assign chars.valid       = valid_q;
	assign chars.code_point  = code_q;
	assign chars.char_valid  = char_q;
	assign chars.message_end = end_q;

	always_comb begin
		load      = pop_valid && (!valid_q || chars.ready);
		slot      = idx_q ? pop_entry.second : pop_entry.first;
		last      = !pop_entry.two || idx_q;
		pop_ready = load && last;
		if (!slot.is_char) begin
			cp = 16'd0;
		end else if (slot.ext) begin
			cp = gsu_ext_lookup(slot.septet);
		end else begin
			cp = GSU_BASIC_SET[slot.septet];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q <= cp;
			char_q <= slot.is_char;
			end_q  <= slot.msg_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= !last;
			end else if (chars.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule
